// ----- hdl/crcsf_pkg.sv -----
// crcsf_pkg: shared types, constants and functions of the crc stuffed frame encoder
// no dependencies; used by every module under hdl except crcsf_fifo
`default_nettype none

package crcsf_pkg;

  // crc-16/ccitt, msb first, no reflection, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // framing and stuffing bytes
  localparam logic [7:0] LINE_END      = 8'h0A;
  localparam logic [7:0] STUFF_ESC     = 8'h1B;
  localparam logic [7:0] STUFF_FOR_LF  = 8'h01;
  localparam logic [7:0] STUFF_FOR_ESC = 8'h02;

  // reset value of the frame marker register
  localparam logic [7:0] MARKER_RESET = 8'h02;

  // one accepted body byte, classified by the front end
  typedef struct packed {
    logic        mark;     // frame opens here, send marker first
    logic [7:0]  marker;
    logic [7:0]  body;
    logic        last;     // body closes here, crc and terminator follow
    logic [15:0] crc;      // crc including this body byte
  } cmd_t;

  // fold one byte into the running crc
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // byte goes out as an escape pair
  function automatic logic needs_stuff(input logic [7:0] b);
    return (b == LINE_END) || (b == STUFF_ESC);
  endfunction

  // second byte of an escape pair
  function automatic logic [7:0] stuff_code(input logic [7:0] b);
    return (b == LINE_END) ? STUFF_FOR_LF : STUFF_FOR_ESC;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/crcsf_fifo.sv -----
// crcsf_fifo: small register queue between the front end and the back end
// no package dependency; width and depth come from parameters
`default_nettype none

module crcsf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/crcsf_front.sv -----
// crcsf_front: accepts body bytes, updates the crc and frame state, forms the queue requests
// depends on crcsf_pkg
`default_nettype none

module crcsf_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata,
  input  wire logic              accept,
  input  wire logic [7:0]        body_byte,
  input  wire logic              body_last,
  output crcsf_pkg::cmd_t        cmd
);

  logic [7:0]  frame_marker;
  logic        inside_frame;
  logic [15:0] running_crc;
  logic [15:0] crc_next;

  assign crc_next = crcsf_pkg::crc_add_byte(running_crc, body_byte);

  // request handed to the queue
  always_comb begin
    cmd.mark   = !inside_frame;
    cmd.marker = frame_marker;
    cmd.body   = body_byte;
    cmd.last   = body_last;
    cmd.crc    = crc_next;
  end

  // marker register and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_marker <= crcsf_pkg::MARKER_RESET;
      inside_frame <= 1'b0;
      running_crc  <= crcsf_pkg::CRC_INIT;
    end else begin
      if (cfg_we) begin
        frame_marker <= cfg_wdata;
      end
      if (accept) begin
        inside_frame <= !body_last;
        running_crc  <= body_last ? crcsf_pkg::CRC_INIT : crc_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/crcsf_back.sv -----
// crcsf_back: expands queued requests into stuffed wire bytes, one per cycle while the receiver pops
// depends on crcsf_pkg
`default_nettype none

module crcsf_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire crcsf_pkg::cmd_t   q_data,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic [7:0]             wire_byte,
  output logic                   run_end,
  output logic                   frame_end
);

  typedef enum logic [2:0] {
    PH_MARK,
    PH_BODY,
    PH_CRCL,
    PH_CRCH,
    PH_TERM
  } phase_t;

  crcsf_pkg::cmd_t cmd;
  logic            cmd_valid;
  phase_t          phase;
  logic            second;
  logic            out_valid;

  phase_t          phase_next;
  logic            second_next;
  logic [7:0]      src;
  logic [7:0]      byte_next;
  logic            done;
  logic            fend;
  logic            emit;
  logic            load;

  // choose the source byte of this phase
  always_comb begin
    case (phase)
      PH_MARK: src = cmd.marker;
      PH_BODY: src = cmd.body;
      PH_CRCL: src = cmd.crc[7:0];
      PH_CRCH: src = cmd.crc[15:8];
      PH_TERM: src = crcsf_pkg::LINE_END;
      default: src = crcsf_pkg::LINE_END;
    endcase
  end

  // next wire byte and sequencing
  always_comb begin
    phase_next  = phase;
    second_next = 1'b0;
    done        = 1'b0;
    fend        = 1'b0;
    byte_next   = src;
    case (phase)
      PH_MARK: begin
        phase_next = PH_BODY;
      end
      PH_BODY, PH_CRCL, PH_CRCH: begin
        if (crcsf_pkg::needs_stuff(src) && !second) begin
          byte_next   = crcsf_pkg::STUFF_ESC;
          second_next = 1'b1;
        end else begin
          byte_next = second ? crcsf_pkg::stuff_code(src) : src;
          case (phase)
            PH_BODY: begin
              if (cmd.last) begin
                phase_next = PH_CRCL;
              end else begin
                done = 1'b1;
              end
            end
            PH_CRCL: phase_next = PH_CRCH;
            default: phase_next = PH_TERM;
          endcase
        end
      end
      PH_TERM: begin
        fend = 1'b1;
        done = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // emit when the output register is free or being drained
  assign emit  = cmd_valid && (!out_valid || pop);
  assign load  = !q_empty && (!cmd_valid || (emit && done));
  assign q_pop = load;
  assign empty = !out_valid;

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      out_valid <= 1'b0;
      phase     <= PH_MARK;
      second    <= 1'b0;
    end else begin
      // output register
      if (emit) begin
        out_valid <= 1'b1;
        wire_byte <= byte_next;
        run_end   <= done;
        frame_end <= fend;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      // current request and its phase
      if (load) begin
        cmd       <= q_data;
        cmd_valid <= 1'b1;
        phase     <= q_data.mark ? PH_MARK : PH_BODY;
        second    <= 1'b0;
      end else if (emit) begin
        phase  <= phase_next;
        second <= second_next;
        if (done) begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/crc_stuffed_frame_encoder_core.sv -----
// Byte-stuffing frame encoder with CRC-16/CCITT trailer.
// Input queue side: body_byte and body_last are taken at an edge with push high and
// full low. Output queue side: wire_byte, run_end and frame_end show the oldest byte
// while empty is low; it is taken at an edge with pop high and empty low.
// Each frame goes out as marker, stuffed body, stuffed crc (low byte first) and a 0x0A
// terminator; run_end closes the bytes caused by one input byte, frame_end flags the
// terminator. cfg_we/cfg_wdata write the frame marker, picked up at the next frame start.
// With the back end idle, the first wire byte of an input byte passes the queue slot,
// the sequencer's request register and the output register before it shows on the ports.
// Throughput: the back-end sequencer sends one wire byte per cycle while the receiver
// pops, so an input byte yields 1 to 8 wire bytes (1 plain, 2 stuffed, up to 8 on a
// one-byte frame). The front end takes one input byte per cycle until the QUEUE_DEPTH
// request queue fills. When the receiver stalls, the output register holds, the
// sequencer waits, the queue fills and full rises. Reset empties the queue and output,
// sets the marker to 0x02, the crc to 0xFFFF and starts outside a frame.
// Depends on crcsf_pkg, crcsf_front, crcsf_fifo, crcsf_back.
`default_nettype none

module crc_stuffed_frame_encoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] body_byte,
  input  wire logic       body_last,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      wire_byte,
  output logic            run_end,
  output logic            frame_end
);

  localparam int CMD_W = $bits(crcsf_pkg::cmd_t);

  crcsf_pkg::cmd_t front_cmd;
  crcsf_pkg::cmd_t q_data;
  logic            accept;
  logic            q_empty;
  logic            q_pop;

  assign accept = push && !full;

  // classification and crc
  crcsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .body_byte (body_byte),
    .body_last (body_last),
    .cmd       (front_cmd)
  );

  // request queue
  crcsf_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // wire byte sequencer
  crcsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .wire_byte (wire_byte),
    .run_end   (run_end),
    .frame_end (frame_end)
  );

endmodule

`default_nettype wire

// ----- hdl/crcsf_checker.sv -----
// crcsf_checker: port-level assertions for the crc stuffed frame encoder, with bind
// depends on crcsf_pkg and crc_stuffed_frame_encoder_core
`default_nettype none

module crcsf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       pop,
  input wire logic       empty,
  input wire logic [7:0] wire_byte,
  input wire logic       run_end,
  input wire logic       frame_end
);

  // reset leaves nothing waiting on the output
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // terminator carries the line end byte
  a_term_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_end) |-> (wire_byte == crcsf_pkg::LINE_END))
    else $error("frame_end on a byte other than line end");

  // terminator always closes the run of its input byte
  a_term_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_end) |-> run_end)
    else $error("frame_end without run_end");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(wire_byte) && $stable(run_end)))
    else $error("stalled result changed");

endmodule

bind crc_stuffed_frame_encoder_core crcsf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .pop       (pop),
  .empty     (empty),
  .wire_byte (wire_byte),
  .run_end   (run_end),
  .frame_end (frame_end)
);

`default_nettype wire
